FILE: rtl/tilt_complementary_filter_core_assert.svh
// assertion macros for the tilt filter
`ifndef TILT_COMPLEMENTARY_FILTER_CORE_ASSERT_SVH
`define TILT_COMPLEMENTARY_FILTER_CORE_ASSERT_SVH
`define TCF_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("label failed");
`define TCF_ASSERT_NEXT(label, clk, rst, cond, nxt) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error("label failed");
`endif

FILE: rtl/tcf_pkg.sv
// shared types and constants of the tilt filter
package tcf_pkg;
   localparam int TableLen = 24;
   localparam logic signed [31:0] PiQ16 = 32'sd205887;
   localparam logic signed [31:0] TwoPiQ16 = 32'sd411775;
   localparam logic signed [34:0] HalfPiQ29 = 35'sd843314857;
   localparam logic [26:0] RecipK1000 = 27'd68719477;
   localparam logic [1:0] CSR_BLEND = 2'd0;
   localparam logic [1:0] CSR_OFFSET = 2'd1;
   localparam logic [1:0] CSR_GX_DRIFT = 2'd2;
   localparam logic [1:0] CSR_GY_DRIFT = 2'd3;

   typedef struct packed {
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [31:0] gyro_x_rate;
      logic signed [31:0] gyro_y_rate;
      logic [31:0] timestamp_ms;
      logic clear_angle;
   } req_type;

   typedef struct packed {
      logic signed [31:0] balance_angle;
      logic signed [31:0] balance_rate;
      logic signed [31:0] rotation_rate;
      logic [31:0] elapsed_ms;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_LOAD, OP_CORDIC, OP_UNWRAP, OP_GMUL, OP_GDIV, OP_PRED, OP_BMUL, OP_BFIN
   } op_type;

   typedef struct packed {
      logic go;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic cordic_done;
      logic div_done;
   } sts_type;

   function automatic logic signed [34:0] atan_q29(input logic [4:0] i);
      case (i)
         5'd0: atan_q29 = 35'sd421657428;
         5'd1: atan_q29 = 35'sd248918915;
         5'd2: atan_q29 = 35'sd131521918;
         5'd3: atan_q29 = 35'sd66762579;
         5'd4: atan_q29 = 35'sd33510843;
         5'd5: atan_q29 = 35'sd16771758;
         5'd6: atan_q29 = 35'sd8387925;
         5'd7: atan_q29 = 35'sd4194219;
         5'd8: atan_q29 = 35'sd2097141;
         5'd9: atan_q29 = 35'sd1048575;
         5'd10: atan_q29 = 35'sd524288;
         5'd11: atan_q29 = 35'sd262144;
         5'd12: atan_q29 = 35'sd131072;
         5'd13: atan_q29 = 35'sd65536;
         5'd14: atan_q29 = 35'sd32768;
         5'd15: atan_q29 = 35'sd16384;
         5'd16: atan_q29 = 35'sd8192;
         5'd17: atan_q29 = 35'sd4096;
         5'd18: atan_q29 = 35'sd2048;
         5'd19: atan_q29 = 35'sd1024;
         5'd20: atan_q29 = 35'sd512;
         5'd21: atan_q29 = 35'sd256;
         5'd22: atan_q29 = 35'sd128;
         5'd23: atan_q29 = 35'sd64;
         default: atan_q29 = '0;
      endcase
   endfunction

   function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) sat32 = 64'sd2147483647;
      else if (v < -64'sd2147483648) sat32 = -64'sd2147483648;
      else sat32 = v;
   endfunction
endpackage

FILE: rtl/tcf_stream_if.sv
// valid/ready channel carrying one payload
interface tcf_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/tcf_datapath.sv
// datapath: cordic, unwrap, gyro term divider, blend
`include "tilt_complementary_filter_core_assert.svh"
module tcf_datapath #(
   parameter int CORDIC_STEPS = 16
) (
   input logic clock,
   input logic reset,
   input tcf_pkg::cmd_type cmd,
   output tcf_pkg::sts_type sts,
   input tcf_pkg::req_type req_in,
   input logic csr_we,
   input logic [1:0] csr_addr,
   input logic [31:0] csr_wdata,
   output tcf_pkg::rsp_type rsp_out
);
   localparam int StepW = $clog2(CORDIC_STEPS + 1);
   localparam int Steps = (CORDIC_STEPS < tcf_pkg::TableLen) ? CORDIC_STEPS : tcf_pkg::TableLen;

   logic [15:0] blend_ff;
   logic signed [31:0] offset_ff, gxd_ff, gyd_ff;
   logic signed [31:0] prev_tilt_ff, angle_ff;
   logic [31:0] stamp_ff;

   logic signed [34:0] x_ff, y_ff, z_ff;
   logic zero_ff;
   logic [StepW-1:0] step_ff;
   logic signed [31:0] tilt_ff, rate_x_ff, rate_y_ff;
   logic signed [32:0] accel_ff;
   logic [31:0] elapsed_ff;
   logic clear_ff;
   logic [63:0] num_ff;
   logic [63:0] quo_ff;
   logic [9:0] rem_ff;
   logic [1:0] dcnt_ff;
   logic signed [31:0] pred_ff;
   logic signed [63:0] prod_ff;
   tcf_pkg::rsp_type rsp_ff;

   logic signed [34:0] ax, ay;
   logic signed [34:0] sy, sx;
   logic signed [32:0] tilt_w, delta, tilt_u;
   logic [31:0] mag_x;
   logic [25:0] div_v;
   logic [63:0] div_p;
   logic [15:0] div_q;
   logic [25:0] div_r;
   logic signed [63:0] gterm, predsum, bl, bl2;
   logic signed [16:0] alpha_s;

   always_comb begin
      ax = 35'(req_in.accel_z) <<< 14;
      ay = 35'(req_in.accel_y) <<< 14;
      sy = y_ff >>> step_ff;
      sx = x_ff >>> step_ff;
      tilt_w = zero_ff ? '0 : 33'(( 36'(z_ff) + 36'sd4096) >>> 13);
      delta = tilt_w - 33'(prev_tilt_ff);
      if (delta > 33'(tcf_pkg::PiQ16)) tilt_u = tilt_w - 33'(tcf_pkg::TwoPiQ16);
      else if (delta < -33'(tcf_pkg::PiQ16)) tilt_u = tilt_w + 33'(tcf_pkg::TwoPiQ16);
      else tilt_u = tilt_w;
      mag_x = rate_x_ff[31] ? 32'(-33'(rate_x_ff)) : 32'(rate_x_ff);
      // one 16-bit digit per cycle, quotient digit by reciprocal multiply
      div_v = {rem_ff, num_ff[63:48]};
      div_p = 64'(div_v) * 64'(tcf_pkg::RecipK1000);
      div_q = div_p[51:36];
      div_r = div_v - 26'(32'(div_q) * 32'd1000);
      gterm = rate_x_ff[31] ? -$signed(quo_ff) : $signed(quo_ff);
      predsum = tcf_pkg::sat32(64'(angle_ff) + gterm);
      alpha_s = $signed({1'b0, blend_ff});
      bl = prod_ff + (64'sd65536 - 64'(alpha_s)) * 64'(accel_ff);
      bl2 = tcf_pkg::sat32((bl + 64'sd32768) >>> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff <= 16'd65339;
         offset_ff <= -32'sd102944;
         gxd_ff <= -32'sd5723;
         gyd_ff <= 32'sd790;
         prev_tilt_ff <= '0;
         angle_ff <= '0;
         stamp_ff <= '0;
         step_ff <= '0;
         dcnt_ff <= '0;
         rem_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               tcf_pkg::CSR_BLEND: blend_ff <= csr_wdata[15:0];
               tcf_pkg::CSR_OFFSET: offset_ff <= csr_wdata;
               tcf_pkg::CSR_GX_DRIFT: gxd_ff <= csr_wdata;
               tcf_pkg::CSR_GY_DRIFT: gyd_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.go) begin
            unique case (cmd.op)
               tcf_pkg::OP_LOAD: begin
                  zero_ff <= (req_in.accel_y == '0) && (req_in.accel_z == '0);
                  if (ax < 0) begin
                     if (ay >= 0) begin
                        x_ff <= ay; y_ff <= -ax; z_ff <= tcf_pkg::HalfPiQ29;
                     end else begin
                        x_ff <= -ay; y_ff <= ax; z_ff <= -tcf_pkg::HalfPiQ29;
                     end
                  end else begin
                     x_ff <= ax; y_ff <= ay; z_ff <= '0;
                  end
                  step_ff <= '0;
                  elapsed_ff <= req_in.timestamp_ms - stamp_ff;
                  stamp_ff <= req_in.timestamp_ms;
                  rate_x_ff <= 32'(tcf_pkg::sat32(64'(req_in.gyro_x_rate) - 64'(gxd_ff)));
                  rate_y_ff <= 32'(tcf_pkg::sat32(64'(req_in.gyro_y_rate) - 64'(gyd_ff)));
                  clear_ff <= req_in.clear_angle;
               end
               tcf_pkg::OP_CORDIC: begin
                  if (y_ff >= 0) begin
                     x_ff <= x_ff + sy; y_ff <= y_ff - sx;
                     z_ff <= z_ff + tcf_pkg::atan_q29(5'(step_ff));
                  end else begin
                     x_ff <= x_ff - sy; y_ff <= y_ff + sx;
                     z_ff <= z_ff - tcf_pkg::atan_q29(5'(step_ff));
                  end
                  step_ff <= step_ff + 1'b1;
               end
               tcf_pkg::OP_UNWRAP: begin
                  tilt_ff <= 32'(tilt_u);
                  prev_tilt_ff <= 32'(tilt_u);
                  accel_ff <= tilt_u - 33'(offset_ff);
                  if (clear_ff) angle_ff <= '0;
               end
               tcf_pkg::OP_GMUL: begin
                  num_ff <= 64'(mag_x) * 64'(elapsed_ff) + 64'd500;
                  rem_ff <= '0;
                  dcnt_ff <= '0;
               end
               tcf_pkg::OP_GDIV: begin
                  num_ff <= {num_ff[47:0], 16'd0};
                  quo_ff <= {quo_ff[47:0], div_q};
                  rem_ff <= div_r[9:0];
                  dcnt_ff <= dcnt_ff + 1'b1;
               end
               tcf_pkg::OP_PRED: pred_ff <= 32'(predsum);
               tcf_pkg::OP_BMUL: prod_ff <= 64'(alpha_s) * 64'(pred_ff);
               tcf_pkg::OP_BFIN: begin
                  angle_ff <= 32'(bl2);
                  rsp_ff.balance_angle <= 32'(bl2);
                  rsp_ff.balance_rate <= rate_x_ff;
                  rsp_ff.rotation_rate <= rate_y_ff;
                  rsp_ff.elapsed_ms <= elapsed_ff;
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      sts.cordic_done = (32'(step_ff) == 32'(Steps - 1));
      sts.div_done = (dcnt_ff == 2'd3);
   end
   assign rsp_out = rsp_ff;

   `TCF_ASSERT_IMPL(a_step_bound, clock, reset, 32'(step_ff) <= 32'(Steps))
   `TCF_ASSERT_IMPL(a_rem_bound, clock, reset, rem_ff < 10'd1000)
   `TCF_ASSERT_NEXT(a_prev_tracks, clock, reset, cmd.go && cmd.op == tcf_pkg::OP_UNWRAP, prev_tilt_ff == tilt_ff)
endmodule

FILE: rtl/tcf_control.sv
// sequencer for one transaction
`include "tilt_complementary_filter_core_assert.svh"
module tcf_control (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input logic rsp_ready,
   output tcf_pkg::cmd_type cmd,
   input tcf_pkg::sts_type sts
);
   typedef enum logic [3:0] {
      S_IDLE, S_CORDIC, S_UNWRAP, S_GMUL, S_GDIV, S_PRED, S_BMUL, S_BFIN, S_OUT
   } state_type;
   state_type state_ff;
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_CORDIC;
            S_CORDIC: if (sts.cordic_done) state_ff <= S_UNWRAP;
            S_UNWRAP: state_ff <= S_GMUL;
            S_GMUL: state_ff <= S_GDIV;
            S_GDIV: if (sts.div_done) state_ff <= S_PRED;
            S_PRED: state_ff <= S_BMUL;
            S_BMUL: state_ff <= S_BFIN;
            S_BFIN: if (!rsp_valid_ff || rsp_ready) begin
               state_ff <= S_IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (rsp_valid_ff && rsp_ready && !(state_ff == S_BFIN)) rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      req_ready = (state_ff == S_IDLE);
      rsp_valid = rsp_valid_ff;
      cmd.go = 1'b0;
      cmd.op = tcf_pkg::OP_LOAD;
      unique case (state_ff)
         S_IDLE: begin cmd.go = req_valid; cmd.op = tcf_pkg::OP_LOAD; end
         S_CORDIC: begin cmd.go = 1'b1; cmd.op = tcf_pkg::OP_CORDIC; end
         S_UNWRAP: begin cmd.go = 1'b1; cmd.op = tcf_pkg::OP_UNWRAP; end
         S_GMUL: begin cmd.go = 1'b1; cmd.op = tcf_pkg::OP_GMUL; end
         S_GDIV: begin cmd.go = 1'b1; cmd.op = tcf_pkg::OP_GDIV; end
         S_PRED: begin cmd.go = 1'b1; cmd.op = tcf_pkg::OP_PRED; end
         S_BMUL: begin cmd.go = 1'b1; cmd.op = tcf_pkg::OP_BMUL; end
         S_BFIN: begin cmd.go = !rsp_valid_ff || rsp_ready; cmd.op = tcf_pkg::OP_BFIN; end
         default: ;
      endcase
   end

   `TCF_ASSERT_IMPL(a_busy_no_accept, clock, reset, (state_ff != S_IDLE) |-> !req_ready)
   `TCF_ASSERT_NEXT(a_fin_valid, clock, reset, state_ff == S_BFIN && cmd.go, rsp_valid)
   `TCF_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == S_CORDIC)
endmodule

FILE: rtl/tilt_complementary_filter_core.sv
// top level of the tilt complementary filter
// channel  dir  handshake          payload
// req      in   req_valid/ready    accel, gyro, timestamp, clear flag
// rsp      out  rsp_valid/ready    balance angle, rates, elapsed time
// csr      in   csr_we             index csr_addr, data csr_wdata
// transaction length is set by the cordic loop
// and the four-digit divide by 1000 of the gyro term
// synchronous reset restores register defaults and clears state
// a waiting result holds the finish step until rsp_ready
module tilt_complementary_filter_core #(
   parameter int CORDIC_STEPS = 16
) (
   input logic clock,
   input logic reset,
   tcf_stream_if.sink req,
   tcf_stream_if.source rsp,
   input logic csr_we,
   input logic [1:0] csr_addr,
   input logic [31:0] csr_wdata
);
   tcf_pkg::cmd_type cmd;
   tcf_pkg::sts_type sts;
   tcf_pkg::rsp_type rsp_data;

   tcf_control u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd, .sts
   );

   tcf_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_in(req.data), .csr_we, .csr_addr, .csr_wdata,
      .rsp_out(rsp_data)
   );

   assign rsp.data = rsp_data;
endmodule
